// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge once reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/tmip_pkg.sv
package tmip_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 16;
    localparam int FRAME_W  = 10;
    localparam int MAX_W    = 32;
    localparam int CFG_W    = 10;
    localparam int ROOT_STEPS_W = 4;

    // Configuration register indexes
    localparam logic CFG_VECTOR_MODE = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_ROOT,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic load_sq;
        logic acc;
        logic root_start;
        logic root_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic vec;
        logic root_done;
        logic out_free;
    } t_dp_sts;

endpackage

// File: src/tmip_ctrl.sv
`include "assert_macros.svh"

module tmip_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tmip_pkg::t_dp_sts i_sts,
    output tmip_pkg::t_dp_cmd o_cmd
);
    import tmip_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (i_sts.last) begin
                    n_state = i_sts.vec ? ST_ROOT : ST_PUSH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ROOT: begin
                if (i_sts.root_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.load_in = i_valid;
            end
            ST_MUL: begin
                o_cmd.load_sq = 1'b1;
            end
            ST_ACC: begin
                o_cmd.acc        = 1'b1;
                o_cmd.root_start = i_sts.last & i_sts.vec;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
            end
            ST_PUSH: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `ASSERT_CLK(a_out_slot_free, i_clk, i_rst_n, o_cmd.load_out |-> i_sts.out_free, "result loaded into a busy output register")
    `ASSERT_CLK(a_acc_after_mul, i_clk, i_rst_n, (r_state == ST_ACC) |-> $past(r_state == ST_MUL), "accumulate without a square stage")
    `ASSERT_CLK(a_root_runs, i_clk, i_rst_n, (r_state == ST_ROOT && !i_sts.root_done) |=> (r_state == ST_ROOT), "square root left early")

endmodule

// File: src/tmip_datapath.sv
`include "assert_macros.svh"

module tmip_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [tmip_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic signed [tmip_pkg::SAMPLE_W-1:0]  i_sample_x,
    input  logic signed [tmip_pkg::SAMPLE_W-1:0]  i_sample_y,
    input  logic signed [tmip_pkg::SAMPLE_W-1:0]  i_sample_z,
    input  logic                                  i_stall,
    output logic                                  o_valid,
    output logic [tmip_pkg::VALUE_W-1:0]          o_tmip_value,
    input  tmip_pkg::t_dp_cmd                     i_cmd,
    output tmip_pkg::t_dp_sts                     o_sts
);
    import tmip_pkg::*;

    logic               r_vector_mode;
    logic [FRAME_W-1:0] r_frame_count;

    logic signed [SAMPLE_W-1:0] r_sx;
    logic signed [SAMPLE_W-1:0] r_sy;
    logic signed [SAMPLE_W-1:0] r_sz;
    logic [MAX_W-2:0]           r_qx;
    logic [MAX_W-2:0]           r_qy;
    logic [MAX_W-2:0]           r_qz;
    logic [MAX_W-1:0]           r_max;
    logic [FRAME_W-1:0]         r_idx;
    logic [MAX_W-1:0]           r_rem;
    logic [MAX_W-1:0]           r_root;
    logic [ROOT_STEPS_W-1:0]    r_rk;
    logic [VALUE_W-1:0]         r_res;
    logic                       r_out_valid;
    logic [VALUE_W-1:0]         r_out;

    logic signed [MAX_W-1:0] w_px;
    logic signed [MAX_W-1:0] w_py;
    logic signed [MAX_W-1:0] w_pz;
    logic [MAX_W-1:0]        w_cand;
    logic [MAX_W-1:0]        w_newmax;
    logic [FRAME_W-1:0]      w_next_idx;
    logic                    w_last;
    logic [MAX_W-1:0]        w_bit;
    logic [MAX_W:0]          w_trial;
    logic                    w_take;
    logic [MAX_W-1:0]        w_root_nx;
    logic [VALUE_W-1:0]      w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_mode <= 1'b0;
            r_frame_count <= FRAME_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VECTOR_MODE: r_vector_mode <= i_cfg_data[0];
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[FRAME_W-1:0];
                default: r_vector_mode <= r_vector_mode;
            endcase
        end
    end

    // Squares of signed samples are never negative; (-2^15)^2 fits in 31 bits.
    assign w_px = r_sx * r_sx;
    assign w_py = r_sy * r_sy;
    assign w_pz = r_sz * r_sz;

    assign w_cand     = MAX_W'(r_qx) + MAX_W'(r_qy) + MAX_W'(r_qz);
    assign w_newmax   = (w_cand > r_max) ? w_cand : r_max;
    assign w_next_idx = r_idx + FRAME_W'(1);
    assign w_last     = (w_next_idx == r_frame_count);
    assign w_sat      = (|w_newmax[MAX_W-1:VALUE_W]) ? '1 : w_newmax[VALUE_W-1:0];

    // Digit-by-digit square root, one result bit per step
    assign w_bit     = 32'h4000_0000 >> {r_rk, 1'b0};
    assign w_trial   = {1'b0, r_root} + {1'b0, w_bit};
    assign w_take    = ({1'b0, r_rem} >= w_trial);
    assign w_root_nx = w_take ? ((r_root >> 1) + w_bit) : (r_root >> 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sx <= i_sample_x;
            r_sy <= i_sample_y;
            r_sz <= i_sample_z;
        end
        if (i_cmd.load_sq) begin
            if (r_vector_mode) begin
                r_qx <= w_px[MAX_W-2:0];
                r_qy <= w_py[MAX_W-2:0];
                r_qz <= w_pz[MAX_W-2:0];
            end else begin
                r_qx <= r_sx[SAMPLE_W-1] ? '0 : (MAX_W-1)'(r_sx);
                r_qy <= '0;
                r_qz <= '0;
            end
        end
        if (i_cmd.acc && w_last && !r_vector_mode) begin
            r_res <= w_sat;
        end
        if (i_cmd.root_start) begin
            r_rem  <= w_newmax;
            r_root <= '0;
            r_rk   <= '0;
        end else if (i_cmd.root_step) begin
            if (w_take) begin
                r_rem <= r_rem - w_trial[MAX_W-1:0];
            end
            r_root <= w_root_nx;
            r_rk   <= r_rk + ROOT_STEPS_W'(1);
            if (&r_rk) begin
                r_res <= w_root_nx[VALUE_W-1:0];
            end
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                if (w_last) begin
                    r_max <= '0;
                    r_idx <= '0;
                end else begin
                    r_max <= w_newmax;
                    r_idx <= w_next_idx;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last      = w_last;
    assign o_sts.vec       = r_vector_mode;
    assign o_sts.root_done = &r_rk;
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid      = r_out_valid;
    assign o_tmip_value = r_out;

    `ASSERT_CLK(a_voxel_clear, i_clk, i_rst_n, (i_cmd.acc && w_last) |=> (r_max == '0 && r_idx == '0), "voxel state not cleared after last frame")
    `ASSERT_CLK(a_root_range, i_clk, i_rst_n, (i_cmd.root_step && (&r_rk)) |-> (w_root_nx <= 32'd56755), "square root out of range")

endmodule

// File: src/temporal_max_intensity_projection.sv
// A sample is taken in, squared and summed over x, y, z (scalar mode: x only, clamped at zero),
// then compared against the running maximum; a new sample waits until it is through. The last
// frame of a voxel loads the result register, in vector mode after the 16-step digit-serial root.
// The result register frees the input side while a result waits for its transfer.
// Reset (i_rst_n, synchronous, active low): scalar mode, frame count 1, running max and frame
// index cleared, no result pending.
`include "assert_macros.svh"

module temporal_max_intensity_projection (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [tmip_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [tmip_pkg::SAMPLE_W-1:0]  i_sample_x,
    input  logic signed [tmip_pkg::SAMPLE_W-1:0]  i_sample_y,
    input  logic signed [tmip_pkg::SAMPLE_W-1:0]  i_sample_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [tmip_pkg::VALUE_W-1:0]          o_tmip_value
);
    import tmip_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tmip_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tmip_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_x   (i_sample_x),
        .i_sample_y   (i_sample_y),
        .i_sample_z   (i_sample_z),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_tmip_value (o_tmip_value),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts)
    );

    `ASSERT_ALWAYS(a_reset_no_result, i_clk, !i_rst_n |=> !o_valid, "result pending right after reset")

endmodule
